@@ hw/rtl/breathing_triangle_duty_generator_defines.svh @@
// ----------------------------------------------------------------------------
// Breathing triangle duty generator assertion macros
// Shared assertion forms for the checker that watches the top-level ports.
// ----------------------------------------------------------------------------
`ifndef BREATHING_TRIANGLE_DUTY_GENERATOR_DEFINES_SVH
`define BREATHING_TRIANGLE_DUTY_GENERATOR_DEFINES_SVH

// Same-cycle implication, held off while reset is asserted.
`define BTDG_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("btdg: same-cycle check failed");

// Next-cycle implication, held off while reset is asserted.
`define BTDG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("btdg: next-cycle check failed");

`endif

@@ hw/rtl/btdg_pkg.sv @@
// ----------------------------------------------------------------------------
// Breathing triangle duty generator package
// Register indexes, field widths and word layouts shared by the RTL files.
// ----------------------------------------------------------------------------
package btdg_pkg;

    localparam int DUTY_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // input word: tick in bit 0, padded to a byte
    localparam int S_TDATA_W  = 8;
    // output word: led_duty, fan_duty, rising, padded to whole bytes
    localparam int M_TDATA_W  = 40;
    localparam int LED_LSB    = 0;
    localparam int FAN_LSB    = 16;
    localparam int RISING_BIT = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CYCLE_LENGTH  = 3'd0,
        REG_LED_MAX       = 3'd1,
        REG_LED_MIN       = 3'd2,
        REG_FAN_MAX       = 3'd3,
        REG_FAN_MIN       = 3'd4,
        REG_LED_STEP      = 3'd5,
        REG_FAN_STEP      = 3'd6,
        REG_FAN_HOLD_MODE = 3'd7
    } cfg_index_t;

endpackage

@@ hw/rtl/breathing_triangle_duty_generator.sv @@
// ----------------------------------------------------------------------------
// Breathing triangle duty generator
// Two-channel triangle breathing envelope (LED and fan) advanced per tick.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake              | word
//  s_*      | in        | s_tvalid / s_tready    | tick
//  m_*      | out       | m_tvalid / m_tready    | led_duty, fan_duty, rising
//  cfg_*    | in        | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One input word per cycle; its result appears in the output register on the
// next cycle. The sustained rate is one word per clock while m_tready is high.
// On a step each channel does at most one 16-bit add or subtract; the phase compare is shared.
// s_tready drops only while a result sits in the output register unread.
// rst_n clears all state and registers but the output data word; direction resets to rising.
// cfg_ready is always high.
module breathing_triangle_duty_generator
    import btdg_pkg::*;
#(
    parameter int STEP_DELAY = 1
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // [0] tick, [7:1] zero
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // [15:0] led_duty, [31:16] fan_duty,
                                             // [32] rising, [39:33] zero
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int DELAY_W_RAW = $clog2(STEP_DELAY + 1);
    localparam int DELAY_W     = (DELAY_W_RAW < 1) ? 1 : DELAY_W_RAW;
    localparam logic [DELAY_W-1:0] DELAY_LIMIT = DELAY_W'(STEP_DELAY);

    logic [DUTY_W-1:0]  cycle_length_reg;
    logic [DUTY_W-1:0]  led_max_reg;
    logic [DUTY_W-1:0]  led_min_reg;
    logic [DUTY_W-1:0]  fan_max_reg;
    logic [DUTY_W-1:0]  fan_min_reg;
    logic [DUTY_W-1:0]  led_step_reg;
    logic [DUTY_W-1:0]  fan_step_reg;
    logic               fan_hold_reg;

    logic [DUTY_W-1:0]  phase_reg,  phase_next;
    logic [DELAY_W-1:0] delay_reg,  delay_next;
    logic               up_reg,     up_next;
    logic [DUTY_W-1:0]  led_reg,    led_next;
    logic [DUTY_W-1:0]  fan_reg,    fan_next;

    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic s_accept;
    logic tick_fire;
    logic flip;
    logic step;

    assign cfg_ready = 1'b1;
    assign s_tready  = !m_tvalid_reg || m_tready;
    assign s_accept  = s_tvalid && s_tready;
    assign tick_fire = s_accept && s_tdata[0];
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cycle_length_reg <= '0;
            led_max_reg      <= '0;
            led_min_reg      <= '0;
            fan_max_reg      <= '0;
            fan_min_reg      <= '0;
            led_step_reg     <= '0;
            fan_step_reg     <= '0;
            fan_hold_reg     <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_CYCLE_LENGTH:  cycle_length_reg <= cfg_data;
                REG_LED_MAX:       led_max_reg      <= cfg_data;
                REG_LED_MIN:       led_min_reg      <= cfg_data;
                REG_FAN_MAX:       fan_max_reg      <= cfg_data;
                REG_FAN_MIN:       fan_min_reg      <= cfg_data;
                REG_LED_STEP:      led_step_reg     <= cfg_data;
                REG_FAN_STEP:      fan_step_reg     <= cfg_data;
                REG_FAN_HOLD_MODE: fan_hold_reg     <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    assign flip = phase_reg >= cycle_length_reg;
    assign step = delay_reg >= DELAY_LIMIT;

    always_comb
    begin
        phase_next = phase_reg;
        delay_next = delay_reg;
        up_next    = up_reg;
        led_next   = led_reg;
        fan_next   = fan_reg;
        if (tick_fire)
        begin
            if (flip)
            begin
                // snap to the end value of this half and reverse
                led_next   = up_reg ? led_max_reg : led_min_reg;
                fan_next   = up_reg ? fan_max_reg : fan_min_reg;
                up_next    = !up_reg;
                phase_next = '0;
                delay_next = '0;
            end
            else if (step)
            begin
                if (fan_hold_reg)
                    fan_next = up_reg ? fan_max_reg : fan_min_reg;
                else
                    fan_next = up_reg ? DUTY_W'(fan_reg + fan_step_reg)
                                      : DUTY_W'(fan_reg - fan_step_reg);
                led_next   = up_reg ? DUTY_W'(led_reg + led_step_reg)
                                    : DUTY_W'(led_reg - led_step_reg);
                delay_next = '0;
                phase_next = DUTY_W'(phase_reg + 1'b1);
            end
            else
            begin
                delay_next = DELAY_W'(delay_reg + 1'b1);
                phase_next = DUTY_W'(phase_reg + 1'b1);
            end
        end
    end

    always_comb
    begin
        m_tdata_next = '0;
        m_tdata_next[LED_LSB +: DUTY_W] = led_next;
        m_tdata_next[FAN_LSB +: DUTY_W] = fan_next;
        m_tdata_next[RISING_BIT]        = up_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= '0;
            delay_reg    <= '0;
            up_reg       <= 1'b1;
            led_reg      <= '0;
            fan_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            delay_reg <= delay_next;
            up_reg    <= up_next;
            led_reg   <= led_next;
            fan_reg   <= fan_next;
            if (s_accept)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    // result word: load on accept, hold otherwise
    always_ff @(posedge clk)
    begin
        if (s_accept)
            m_tdata_reg <= m_tdata_next;
    end

endmodule

@@ hw/rtl/btdg_checker.sv @@
// ----------------------------------------------------------------------------
// Breathing triangle duty generator port checker
// Watches the top-level handshakes over time; bound to the top level.
// ----------------------------------------------------------------------------
`include "breathing_triangle_duty_generator_defines.svh"

module btdg_checker
    import btdg_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    // a stalled result word holds
    `BTDG_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // every accepted word yields a result on the next cycle
    `BTDG_ASSERT_NEXT(a_in_to_out, s_tvalid && s_tready, m_tvalid)

    // an empty output register never blocks input
    `BTDG_ASSERT_NOW(a_ready_empty, !m_tvalid, s_tready)

    // one result slot: an unread result blocks input
    `BTDG_ASSERT_NOW(a_ready_full, m_tvalid && !m_tready, !s_tready)

endmodule

bind breathing_triangle_duty_generator btdg_checker u_btdg_checker (.*);
